### rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/ansi16_pkg.sv
// shared types, palette and mode codes for the ansi16 colour matcher
// no dependencies
`default_nettype none

package ansi16_pkg;

    localparam int PAL_N   = 16;
    localparam int IDX_W   = 4;
    localparam int CH_W    = 8;
    localparam int SQ_W    = 2 * CH_W;
    localparam int WGT_W   = 10;
    localparam int PROD_W  = SQ_W + WGT_W;
    localparam int DIST_W  = 28;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_DARK   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BRIGHT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALL    = 2'd2;

    typedef logic [CH_W-1:0]   t_chan;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [DIST_W-1:0] t_dist;
    typedef logic [PAL_N-1:0][DIST_W-1:0] t_dist_vec;

    typedef struct packed {
        logic en;
        logic vld;
    } t_stage_ctl;

    typedef struct packed {
        logic  ok;
        t_dist d;
        t_idx  idx;
    } t_cand;

    localparam t_chan PAL_R [PAL_N] = '{
        8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd192,
        8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    localparam t_chan PAL_G [PAL_N] = '{
        8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd192,
        8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255};
    localparam t_chan PAL_B [PAL_N] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd192,
        8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};

    // lower index wins unless the other is strictly closer
    function automatic t_cand pick(input t_cand a, input t_cand b);
        if (b.ok && (!a.ok || (b.d < a.d))) begin
            return b;
        end
        return a;
    endfunction

endpackage

`default_nettype wire

### rtl/ansi16_if.sv
// stream interfaces: pixel in, colour index out, mode write port
// depends on ansi16_pkg
`default_nettype none

interface ansi16_pix_if import ansi16_pkg::*;;
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;
    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ansi16_idx_if import ansi16_pkg::*;;
    logic valid;
    logic ready;
    t_idx color_index;
    modport source (output valid, output color_index, input ready);
    modport sink   (input valid, input color_index, output ready);
endinterface

interface ansi16_cfg_if import ansi16_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] palette_mode;
    modport source (output valid, output palette_mode, input ready);
    modport sink   (input valid, input palette_mode, output ready);
endinterface

`default_nettype wire

### rtl/nearest_ansi16_color_match_core.sv
// throughput: one pixel per cycle, set by the five-stage pipeline that
// advances as a whole whenever the output register is empty or taken
// reset: clears every stage valid bit, empties the output and sets the
// palette mode to all sixteen colours
// top level: mode register, pipeline control, distance lanes and minimum tree
`default_nettype none
`include "assert_macros.svh"

module nearest_ansi16_color_match_core import ansi16_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    ansi16_cfg_if.sink        i_cfg,
    ansi16_pix_if.sink        i_pix,
    ansi16_idx_if.source      o_idx
);

    logic [MODE_W-1:0] r_mode;
    logic              n_en;
    t_stage_ctl        n_in_ctl;
    t_stage_ctl        n_tree_ctl;
    logic              n_dist_vld;
    t_dist_vec         n_dist;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ALL;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.palette_mode;
        end
    end

    assign n_en        = !o_idx.valid || o_idx.ready;
    assign i_pix.ready = n_en;
    assign n_in_ctl    = '{en: n_en, vld: i_pix.valid};
    assign n_tree_ctl  = '{en: n_en, vld: n_dist_vld};

    ansi16_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_in_ctl),
        .i_red   (i_pix.red),
        .i_green (i_pix.green),
        .i_blue  (i_pix.blue),
        .o_vld   (n_dist_vld),
        .o_dist  (n_dist)
    );

    ansi16_argmin u_argmin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (n_tree_ctl),
        .i_mode  (r_mode),
        .i_dist  (n_dist),
        .o_vld   (o_idx.valid),
        .o_idx   (o_idx.color_index)
    );

    `ASSERT_IMPL(a_bright_range, i_clk, i_rst_n,
        o_idx.valid && (r_mode == MODE_BRIGHT), o_idx.color_index[IDX_W-1])
    `ASSERT_IMPL(a_dark_range, i_clk, i_rst_n,
        o_idx.valid && (r_mode != MODE_BRIGHT) && (r_mode != MODE_ALL),
        !o_idx.color_index[IDX_W-1])
    `ASSERT_NEXT(a_cfg_write, i_clk, i_rst_n,
        i_cfg.valid, r_mode == $past(i_cfg.palette_mode))

endmodule

`default_nettype wire

### rtl/ansi16_dist.sv
// three-stage redmean distance lanes, one per palette entry
// depends on ansi16_pkg
`default_nettype none

module ansi16_dist import ansi16_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_stage_ctl i_ctl,
    input  t_chan      i_red,
    input  t_chan      i_green,
    input  t_chan      i_blue,
    output logic       o_vld,
    output t_dist_vec  o_dist
);

    logic r_vld1, r_vld2, r_vld3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld1 <= i_ctl.vld;
            r_vld2 <= r_vld1;
            r_vld3 <= r_vld2;
        end
    end

    assign o_vld = r_vld3;

    for (genvar k = 0; k < PAL_N; k++) begin : g_lane
        logic [CH_W-1:0]   n_dr, n_dg, n_db;
        logic [CH_W:0]     n_rsum;
        logic [SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
        logic [CH_W-1:0]   r_rmean;
        logic [WGT_W-1:0]  n_wr, n_wb;
        logic [PROD_W-1:0] r_pr, r_pg, r_pb;
        t_dist             r_d;

        always_comb begin
            n_dr   = (i_red >= PAL_R[k]) ? i_red - PAL_R[k] : PAL_R[k] - i_red;
            n_dg   = (i_green >= PAL_G[k]) ? i_green - PAL_G[k] : PAL_G[k] - i_green;
            n_db   = (i_blue >= PAL_B[k]) ? i_blue - PAL_B[k] : PAL_B[k] - i_blue;
            n_rsum = {1'b0, i_red} + {1'b0, PAL_R[k]};
            n_wr   = WGT_W'(512) + {2'b00, r_rmean};
            n_wb   = WGT_W'(767) - {2'b00, r_rmean};
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                // squares and mean red
                r_sq_r  <= n_dr * n_dr;
                r_sq_g  <= n_dg * n_dg;
                r_sq_b  <= n_db * n_db;
                r_rmean <= n_rsum[CH_W:1];
                // weighted terms
                r_pr <= n_wr * r_sq_r;
                r_pg <= {r_sq_g, 10'b0};
                r_pb <= n_wb * r_sq_b;
                // sum
                r_d <= DIST_W'(r_pr) + DIST_W'(r_pg) + DIST_W'(r_pb);
            end
        end

        assign o_dist[k] = r_d;
    end

endmodule

`default_nettype wire

### rtl/ansi16_argmin.sv
// two-stage registered minimum tree over the sixteen distances
// depends on ansi16_pkg
`default_nettype none

module ansi16_argmin import ansi16_pkg::*; (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_stage_ctl        i_ctl,
    input  logic [MODE_W-1:0] i_mode,
    input  t_dist_vec         i_dist,
    output logic              o_vld,
    output t_idx              o_idx
);

    logic [PAL_N-1:0] n_mask;
    t_cand            n_leaf [PAL_N];
    t_cand            n_l1   [PAL_N/2];
    t_cand            n_l2   [PAL_N/4];
    t_cand            r_l2   [PAL_N/4];
    t_cand            n_l3   [PAL_N/8];
    t_cand            n_top;
    logic             r_vld4, r_vld5;
    t_idx             r_idx;

    always_comb begin
        case (i_mode)
            MODE_BRIGHT: n_mask = {{(PAL_N/2){1'b1}}, {(PAL_N/2){1'b0}}};
            MODE_ALL:    n_mask = {PAL_N{1'b1}};
            default:     n_mask = {{(PAL_N/2){1'b0}}, {(PAL_N/2){1'b1}}};
        endcase
        for (int k = 0; k < PAL_N; k++) begin
            n_leaf[k] = '{ok: n_mask[k], d: i_dist[k], idx: IDX_W'(k)};
        end
        for (int k = 0; k < PAL_N/2; k++) begin
            n_l1[k] = pick(n_leaf[2*k], n_leaf[2*k+1]);
        end
        for (int k = 0; k < PAL_N/4; k++) begin
            n_l2[k] = pick(n_l1[2*k], n_l1[2*k+1]);
        end
        for (int k = 0; k < PAL_N/8; k++) begin
            n_l3[k] = pick(r_l2[2*k], r_l2[2*k+1]);
        end
        n_top = pick(n_l3[0], n_l3[1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld4 <= 1'b0;
            r_vld5 <= 1'b0;
        end else if (i_ctl.en) begin
            r_vld4 <= i_ctl.vld;
            r_vld5 <= r_vld4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_l2  <= n_l2;
            r_idx <= n_top.idx;
        end
    end

    assign o_vld = r_vld5;
    assign o_idx = r_idx;

endmodule

`default_nettype wire

### sim/nearest_ansi16_color_match_core_tb.sv
// self-checking testbench for nearest_ansi16_color_match_core: pixel beats in,
// palette index beats out, checked against an in-bench redmean predictor
// depends on ansi16_pkg and the stream interfaces in ansi16_if.sv
module nearest_ansi16_color_match_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ansi16_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int QUIET_LIMIT     = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 12;

    localparam t_chan TERM_R [16] = '{
        8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd128, 8'd0, 8'd192,
        8'd128, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    localparam t_chan TERM_G [16] = '{
        8'd0, 8'd0, 8'd128, 8'd128, 8'd0, 8'd0, 8'd128, 8'd192,
        8'd128, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0, 8'd255, 8'd255};
    localparam t_chan TERM_B [16] = '{
        8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 8'd128, 8'd128, 8'd192,
        8'd128, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};

    localparam t_chan CORNER_LEVELS [12] = '{
        8'd0, 8'd1, 8'd63, 8'd64, 8'd127, 8'd128, 8'd129, 8'd191, 8'd192, 8'd193,
        8'd254, 8'd255};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_chan             red;
        t_chan             green;
        t_chan             blue;
        logic              known;
        t_idx              want;
    } t_pixel_case;

    localparam t_pixel_case DIRECTED [24] = '{
        '{MODE_ALL,    8'd0,   8'd0,   8'd0,   1'b1, 4'd0},
        '{MODE_ALL,    8'd255, 8'd255, 8'd255, 1'b1, 4'd15},
        '{MODE_ALL,    8'd255, 8'd0,   8'd0,   1'b1, 4'd9},
        '{MODE_ALL,    8'd0,   8'd255, 8'd0,   1'b1, 4'd10},
        '{MODE_ALL,    8'd0,   8'd0,   8'd255, 1'b1, 4'd12},
        '{MODE_ALL,    8'd128, 8'd128, 8'd128, 1'b1, 4'd8},
        '{MODE_ALL,    8'd192, 8'd192, 8'd192, 1'b1, 4'd7},
        '{MODE_ALL,    8'd0,   8'd64,  8'd0,   1'b1, 4'd0},
        '{MODE_ALL,    8'd0,   8'd0,   8'd64,  1'b1, 4'd0},
        '{MODE_ALL,    8'd255, 8'd128, 8'd0,   1'b0, 4'd0},
        '{MODE_ALL,    8'd127, 8'd129, 8'd1,   1'b0, 4'd0},
        '{MODE_ALL,    8'd255, 8'd255, 8'd0,   1'b1, 4'd11},
        '{MODE_DARK,   8'd255, 8'd255, 8'd255, 1'b0, 4'd0},
        '{MODE_DARK,   8'd0,   8'd0,   8'd0,   1'b1, 4'd0},
        '{MODE_DARK,   8'd255, 8'd0,   8'd0,   1'b0, 4'd0},
        '{MODE_DARK,   8'd0,   8'd64,  8'd0,   1'b1, 4'd0},
        '{MODE_BRIGHT, 8'd0,   8'd0,   8'd0,   1'b0, 4'd0},
        '{MODE_BRIGHT, 8'd255, 8'd255, 8'd255, 1'b1, 4'd15},
        '{MODE_BRIGHT, 8'd128, 8'd128, 8'd128, 1'b1, 4'd8},
        '{MODE_BRIGHT, 8'd0,   8'd0,   8'd255, 1'b1, 4'd12},
        '{MODE_SPARE,  8'd0,   8'd0,   8'd0,   1'b1, 4'd0},
        '{MODE_SPARE,  8'd0,   8'd0,   8'd64,  1'b1, 4'd0},
        '{MODE_SPARE,  8'd255, 8'd255, 8'd255, 1'b0, 4'd0},
        '{MODE_ALL,    8'd0,   8'd255, 8'd255, 1'b1, 4'd14}};

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        int                tx_idle;
        int                rx_stall;
        int                count;
        logic              hold;
    } t_phase;

    localparam t_phase PHASES [8] = '{
        '{MODE_ALL,    0,  0,  400, 1'b0},
        '{MODE_DARK,   75, 0,  250, 1'b0},
        '{MODE_BRIGHT, 0,  75, 250, 1'b0},
        '{MODE_SPARE,  32, 32, 200, 1'b0},
        '{MODE_ALL,    32, 32, 250, 1'b0},
        '{MODE_BRIGHT, 0,  0,  200, 1'b1},
        '{MODE_DARK,   0,  75, 150, 1'b0},
        '{MODE_ALL,    75, 0,  150, 1'b0}};

    logic clk = 1'b0;
    logic rst_n;

    logic [MODE_W-1:0] active_mode;
    int   tx_idle_pct    = 0;
    int   rx_stall_pct   = 0;
    int   hold_cycles    = 0;
    int   mismatch_count = 0;
    int   quiet_cycles   = 0;
    t_idx expected_colors [$];
    t_idx next_color;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    ansi16_cfg_if cfg_if ();
    ansi16_pix_if pix_if ();
    ansi16_idx_if idx_if ();

    nearest_ansi16_color_match_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_if),
        .o_idx   (idx_if)
    );

    // redmean distance, weights scaled by 256, first strictly smaller entry kept
    function automatic t_idx nearest_color(input logic [MODE_W-1:0] mode,
                                           input t_chan r, input t_chan g, input t_chan b);
        int lo, hi, best, best_d, d, rm, dr, dg, db;
        lo = 0;
        hi = 8;
        if (mode == MODE_BRIGHT) begin
            lo = 8;
            hi = 16;
        end else if (mode == MODE_ALL) begin
            hi = 16;
        end
        best   = lo;
        best_d = 0;
        for (int i = lo; i < hi; i++) begin
            rm = (int'(r) + int'(TERM_R[i])) >> 1;
            dr = int'(r) - int'(TERM_R[i]);
            dg = int'(g) - int'(TERM_G[i]);
            db = int'(b) - int'(TERM_B[i]);
            d  = (512 + rm) * dr * dr + 1024 * dg * dg + (767 - rm) * db * db;
            if (i == lo || d < best_d) begin
                best   = i;
                best_d = d;
            end
        end
        return t_idx'(best);
    endfunction

    function automatic t_chan pick_channel();
        if ($urandom_range(9) < 3) begin
            return CORNER_LEVELS[$urandom_range(11)];
        end
        return t_chan'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic send_pixel(input t_chan r, input t_chan g, input t_chan b,
                              input logic known, input t_idx want);
        while ($urandom_range(99) < tx_idle_pct) begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.red   <= r;
        pix_if.green <= g;
        pix_if.blue  <= b;
        do @(posedge clk); while (!pix_if.ready);
        expected_colors.push_back(known ? want : nearest_color(active_mode, r, g, b));
    endtask

    // only written once the pipeline has drained
    task automatic write_palette_mode(input logic [MODE_W-1:0] mode);
        pix_if.valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        cfg_if.valid        <= 1'b1;
        cfg_if.palette_mode <= mode;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        active_mode = mode;
    endtask

    // index beat receiver, with an optional long hold-off
    initial begin
        idx_if.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_cycles > 0) begin
                idx_if.ready <= 1'b0;
                hold_cycles--;
            end else begin
                idx_if.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && idx_if.valid && idx_if.ready) begin
            if (expected_colors.size() == 0) begin
                report_mismatch($sformatf("index beat %0d with nothing pending",
                                          idx_if.color_index));
            end else begin
                next_color = expected_colors.pop_front();
                if (idx_if.color_index !== next_color) begin
                    report_mismatch($sformatf("color_index got %0d want %0d",
                                              idx_if.color_index, next_color));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((pix_if.valid && pix_if.ready) || (idx_if.valid && idx_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n               = 1'b0;
        cfg_if.valid        = 1'b0;
        cfg_if.palette_mode = MODE_ALL;
        pix_if.valid        = 1'b0;
        pix_if.red          = '0;
        pix_if.green        = '0;
        pix_if.blue         = '0;
        active_mode         = MODE_ALL;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows start in the reset mode
        foreach (DIRECTED[k]) begin
            if (DIRECTED[k].mode != active_mode) begin
                write_palette_mode(DIRECTED[k].mode);
            end
            send_pixel(DIRECTED[k].red, DIRECTED[k].green, DIRECTED[k].blue,
                       DIRECTED[k].known, DIRECTED[k].want);
        end

        foreach (PHASES[p]) begin
            write_palette_mode(PHASES[p].mode);
            tx_idle_pct  = PHASES[p].tx_idle;
            rx_stall_pct = PHASES[p].rx_stall;
            if (PHASES[p].hold) begin
                hold_cycles = HOLD_OFF_CYCLES;
            end
            repeat (PHASES[p].count) begin
                send_pixel(pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
            end
        end

        pix_if.valid <= 1'b0;
        while (expected_colors.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
